// File: rtl/sevgd_pkg.sv
`timescale 1ns / 1ps

package sevgd_pkg;

    // Longest code: a zero run of CODE_BITS-1 followed by CODE_BITS info bits.
    localparam int CODE_BITS = 32;
    localparam int ZR_W      = $clog2(CODE_BITS);
    localparam int VALUE_W   = 32;
    localparam int LEFT_W    = 16;
    localparam logic [VALUE_W-1:0] MAX_COUNT = 32'd65535;

    // Byte queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic KIND_COUNT   = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               err;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_q_head;

endpackage

// File: rtl/signed_exp_golomb_vector_decoder.sv
`timescale 1ns / 1ps

// Signed order-0 exp-Golomb vector decoder. Bytes come in on the slave stream,
// MSB first; each code is n zeros, then n+1 bits forming d, decoded to d/2 (d
// even) or -(d-1)/2 (d odd). The first code of a vector is its element count
// (tuser 0), then that many elements (tuser 1) follow, tlast on the final one
// or on a zero count; after a vector the rest of the current byte is dropped.
// A zero run of 32, or a count below zero or above 65535, gives one result with
// the error bit set and restarts at a count. Rate: the back end walks one bit
// per cycle while the output register is free, with at most one result per
// cycle; a 4-deep byte queue in front keeps the input side taking transfers
// while the bit engine or the output stalls.
module signed_exp_golomb_vector_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] value, [32] error, [39:33] zero
    output logic        o_m_axis_tlast,   // last
    output logic        o_m_axis_tuser    // kind: 0 count, 1 element
);

    sevgd_pkg::t_q_head w_head;
    logic               w_pop;
    sevgd_pkg::t_result w_res;

    // front: byte queue
    sevgd_byte_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_s_axis_tvalid),
        .i_wr_data  (i_s_axis_tdata),
        .o_wr_ready (o_s_axis_tready),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // back: bit-serial decode with registered output
    sevgd_bit_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {7'd0, w_res.err, w_res.value};
    assign o_m_axis_tlast = w_res.last;
    assign o_m_axis_tuser = w_res.kind;

endmodule

// File: rtl/sevgd_byte_queue.sv
`timescale 1ns / 1ps

module sevgd_byte_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_valid,
    input  logic [7:0]           i_wr_data,
    output logic                 o_wr_ready,
    output sevgd_pkg::t_q_head   o_head,
    input  logic                 i_pop
);

    logic [7:0]                 r_mem [sevgd_pkg::Q_DEPTH];
    logic [sevgd_pkg::Q_AW-1:0] r_wr_ptr;
    logic [sevgd_pkg::Q_AW-1:0] r_rd_ptr;
    logic [sevgd_pkg::Q_CW-1:0] r_count;
    logic                       w_push;
    logic                       w_pop;

    assign o_wr_ready   = (r_count != sevgd_pkg::Q_CW'(sevgd_pkg::Q_DEPTH));
    assign w_push       = i_wr_valid && o_wr_ready;
    assign w_pop        = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/sevgd_bit_engine.sv
`timescale 1ns / 1ps

module sevgd_bit_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sevgd_pkg::t_q_head  i_head,
    output logic                o_pop,
    output logic                o_res_valid,
    output sevgd_pkg::t_result  o_res,
    input  logic                i_res_ready
);

    // current byte, shifted left one bit per step
    logic [7:0] r_byte;
    logic [2:0] r_cnt;
    logic       r_busy;

    logic [sevgd_pkg::ZR_W-1:0]      r_zero_run, n_zero_run;
    logic [sevgd_pkg::CODE_BITS-1:0] r_code,     n_code;
    logic [sevgd_pkg::ZR_W-1:0]      r_to_read,  n_to_read;
    logic                            r_suffix,   n_suffix;
    logic                            r_expect,   n_expect;
    logic [sevgd_pkg::LEFT_W-1:0]    r_left,     n_left;

    logic                 r_out_valid;
    sevgd_pkg::t_result   r_out;

    logic                 w_bit;
    logic                 w_done;
    logic                 w_emit;
    logic                 w_brk;
    logic                 w_neg;
    logic [sevgd_pkg::VALUE_W-1:0] w_mag;
    logic [sevgd_pkg::VALUE_W-1:0] w_val;
    logic [sevgd_pkg::LEFT_W-1:0]  w_left_dec;
    sevgd_pkg::t_result   w_res;
    logic                 w_out_free;
    logic                 w_adv;
    logic                 w_eob;

    assign w_bit      = r_byte[7];
    assign w_out_free = !r_out_valid || i_res_ready;
    assign w_adv      = r_busy && w_out_free;
    assign w_eob      = w_brk || (r_cnt == 3'd0);
    assign o_pop      = i_head.valid && (!r_busy || (w_adv && w_eob));

    always_comb begin
        n_zero_run = r_zero_run;
        n_code     = r_code;
        n_to_read  = r_to_read;
        n_suffix   = r_suffix;
        n_expect   = r_expect;
        n_left     = r_left;
        w_done     = 1'b0;
        w_emit     = 1'b0;
        w_brk      = 1'b0;
        w_res      = '0;
        w_mag      = '0;
        w_neg      = 1'b0;
        w_val      = '0;
        w_left_dec = '0;

        if (!r_suffix) begin
            if (!w_bit) begin
                if (r_zero_run == sevgd_pkg::ZR_W'(sevgd_pkg::CODE_BITS - 1)) begin
                    // zero run too long
                    w_emit     = 1'b1;
                    w_res.kind = r_expect ? sevgd_pkg::KIND_COUNT : sevgd_pkg::KIND_ELEMENT;
                    w_res.err  = 1'b1;
                    w_brk      = 1'b1;
                    n_zero_run = '0;
                    n_code     = '0;
                    n_to_read  = '0;
                    n_suffix   = 1'b0;
                    n_expect   = 1'b1;
                    n_left     = '0;
                end else begin
                    n_zero_run = r_zero_run + 1'b1;
                end
            end else begin
                n_code    = sevgd_pkg::CODE_BITS'(1);
                n_to_read = r_zero_run;
                n_suffix  = 1'b1;
                w_done    = (r_zero_run == '0);
            end
        end else begin
            n_code    = {r_code[sevgd_pkg::CODE_BITS-2:0], w_bit};
            n_to_read = r_to_read - 1'b1;
            w_done    = (r_to_read == sevgd_pkg::ZR_W'(1));
        end

        if (w_done) begin
            // odd d: -(d-1)/2 = -(d>>1); even d: d>>1
            w_neg = n_code[0];
            w_mag = sevgd_pkg::VALUE_W'(n_code >> 1);
            w_val = w_neg ? (~w_mag + 1'b1) : w_mag;
            n_zero_run = '0;
            n_code     = '0;
            n_to_read  = '0;
            n_suffix   = 1'b0;
            w_emit     = 1'b1;
            w_res.value = w_val;
            if (r_expect) begin
                w_res.kind = sevgd_pkg::KIND_COUNT;
                if ((w_neg && (w_mag != '0)) || (w_mag > sevgd_pkg::MAX_COUNT)) begin
                    w_res.err = 1'b1;
                    n_left    = '0;
                    w_brk     = 1'b1;
                end else if (w_mag == '0) begin
                    w_res.value = '0;
                    w_res.last  = 1'b1;
                    w_brk       = 1'b1;
                end else begin
                    n_left   = w_mag[sevgd_pkg::LEFT_W-1:0];
                    n_expect = 1'b0;
                end
            end else begin
                w_res.kind = sevgd_pkg::KIND_ELEMENT;
                w_left_dec = (r_left != '0) ? (r_left - 1'b1) : r_left;
                n_left     = w_left_dec;
                if (w_left_dec == '0) begin
                    w_res.last = 1'b1;
                    n_expect   = 1'b1;
                    w_brk      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_zero_run  <= '0;
            r_code      <= '0;
            r_to_read   <= '0;
            r_suffix    <= 1'b0;
            r_expect    <= 1'b1;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd7;
            end else if (w_adv) begin
                if (w_eob) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end

            if (w_adv) begin
                r_zero_run <= n_zero_run;
                r_code     <= n_code;
                r_to_read  <= n_to_read;
                r_suffix   <= n_suffix;
                r_expect   <= n_expect;
                r_left     <= n_left;
            end

            if (w_adv && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte <= i_head.data;
        end else if (w_adv) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
        if (w_adv && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 80;      // room for the 4-deep byte queue to empty, plus slack
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 190;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [39:0] o_m_axis_tdata;   // [31:0] value, [32] error, [39:33] zero
    logic        o_m_axis_tlast;   // last
    logic        o_m_axis_tuser;   // kind

    signed_exp_golomb_vector_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder model state (mirrors the bit engine, one bit at a time)
    // ------------------------------------------------------------------
    int unsigned   zero_cnt     = 0;
    logic [63:0]   info_acc     = '0;
    int unsigned   info_left    = 0;
    bit            in_info      = 1'b0;
    bit            want_count   = 1'b1;
    int unsigned   elems_left   = 0;

    sevgd_pkg::t_result decoded_fifo[$];   // results decoded but not yet seen on the output
    bit            code_stream[$];    // bits waiting to be packed into bytes, MSB first

    int            fail_count   = 0;
    int            bytes_sent   = 0;
    int            burst_left   = 0;
    int            cycle_count  = 0;
    t_rx_mode      rx_mode      = RX_ALWAYS;
    int            rx_phase     = 0;
    sevgd_pkg::t_result head_result;

    task automatic queue_result(input logic kind, input longint signed v,
                                input logic last, input logic err);
        sevgd_pkg::t_result r;
        r.kind  = kind;
        r.value = v[31:0];
        r.last  = last;
        r.err   = err;
        decoded_fifo.insert(decoded_fifo.size(), r);
    endtask

    task automatic append_bit(input bit b);
        code_stream.insert(code_stream.size(), b);
    endtask

    task automatic clear_code();
        zero_cnt  = 0;
        info_acc  = '0;
        info_left = 0;
        in_info   = 1'b0;
    endtask

    // Walk one byte MSB first; a finished vector or an error drops the rest.
    task automatic golomb_decode_byte(input logic [7:0] b);
        logic [31:0]   d;
        longint signed mag;
        longint signed v;
        bit            done;
        bit            stop;
        stop = 1'b0;
        for (int i = 7; i >= 0 && !stop; i--) begin
            done = 1'b0;
            if (!in_info) begin
                if (!b[i]) begin
                    zero_cnt++;
                    if (zero_cnt >= sevgd_pkg::CODE_BITS) begin
                        queue_result(want_count ? sevgd_pkg::KIND_COUNT
                                                : sevgd_pkg::KIND_ELEMENT,
                                     0, 1'b0, 1'b1);
                        clear_code();
                        want_count = 1'b1;
                        elems_left = 0;
                        stop       = 1'b1;
                    end
                end else begin
                    info_acc  = 64'd1;
                    info_left = zero_cnt;
                    in_info   = 1'b1;
                    done      = (info_left == 0);
                end
            end else begin
                info_acc  = {info_acc[62:0], b[i]};
                info_left--;
                done      = (info_left == 0);
            end

            if (done) begin
                d   = info_acc[31:0];
                mag = {33'd0, d[31:1]};
                v   = d[0] ? -mag : mag;
                clear_code();
                if (want_count) begin
                    if (v < 0 || v > longint'(sevgd_pkg::MAX_COUNT)) begin
                        queue_result(sevgd_pkg::KIND_COUNT, v, 1'b0, 1'b1);
                        elems_left = 0;
                        stop       = 1'b1;
                    end else if (v == 0) begin
                        queue_result(sevgd_pkg::KIND_COUNT, 0, 1'b1, 1'b0);
                        stop = 1'b1;
                    end else begin
                        queue_result(sevgd_pkg::KIND_COUNT, v, 1'b0, 1'b0);
                        elems_left = v[31:0];
                        want_count = 1'b0;
                    end
                end else begin
                    if (elems_left > 0) elems_left--;
                    queue_result(sevgd_pkg::KIND_ELEMENT, v, elems_left == 0, 1'b0);
                    if (elems_left == 0) begin
                        want_count = 1'b1;
                        stop       = 1'b1;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stream writer
    // ------------------------------------------------------------------
    function automatic logic [31:0] code_of(input longint signed v);
        return (v > 0) ? 32'(2 * v) : 32'(1 - 2 * v);
    endfunction

    // Random info word with exactly nbits significant bits.
    function automatic logic [31:0] random_info(input int nbits);
        logic [31:0] top;
        top = 32'd1 << (nbits - 1);
        return ($urandom & (top - 32'd1)) | top;
    endfunction

    function automatic logic [31:0] random_element_info();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)      return random_info($urandom_range(1, 8));
        else if (pick < 9) return random_info($urandom_range(9, 20));
        else               return random_info($urandom_range(21, 32));
    endfunction

    task automatic append_code(input logic [31:0] d);
        int top;
        top = 31;
        while (!d[top]) top--;
        repeat (top) append_bit(1'b0);
        for (int i = top; i >= 0; i--) append_bit(d[i]);
    endtask

    task automatic append_zeros(input int n);
        repeat (n) append_bit(1'b0);
    endtask

    // One byte per transfer; bursts of random length with random gaps.
    task automatic send_byte(input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        golomb_decode_byte(b);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Pad to a byte boundary with random bits (dropped once a vector closes) and send.
    task automatic flush_stream();
        logic [7:0] b;
        while (code_stream.size() % 8 != 0) append_bit(1'($urandom_range(0, 1)));
        while (code_stream.size() != 0) begin
            for (int i = 7; i >= 0; i--) b[i] = code_stream.pop_front();
            send_byte(b);
        end
    endtask

    // Zero bytes until the decoder sits at a clean count boundary (zero-run error path).
    task automatic realign_to_count();
        while (!(want_count && !in_info && zero_cnt == 0)) send_byte(8'h00);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (decoded_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_value_extremes();
        append_code(code_of(5));
        append_code(code_of(64'sd2147483647));
        append_code(code_of(-64'sd2147483647));
        append_code(code_of(0));
        append_code(code_of(1));
        append_code(code_of(-1));
        flush_stream();
    endtask

    task automatic test_count_specials();
        append_code(code_of(0));      // empty vector, tlast on the count
        flush_stream();
        append_code(code_of(-1));     // negative count
        flush_stream();
    endtask

    task automatic test_zero_run_at_count();
        append_zeros(sevgd_pkg::CODE_BITS);
        flush_stream();
    endtask

    // Count 15: the third byte carries eight one-bit element codes.
    task automatic test_dense_byte();
        append_code(code_of(15));
        repeat (15) append_code(code_of(0));
        flush_stream();
    endtask

    task automatic test_random_vectors();
        int start;
        int pick;
        int n;
        bit drained;
        start   = bytes_sent;
        drained = 1'b0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // well-formed vector
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                append_code(code_of(n));
                repeat (n) append_code(random_element_info());
                flush_stream();
            end else if (pick < 63) begin
                append_code(code_of(0));
                flush_stream();
            end else if (pick < 68) begin
                // negative count, small or up to full width
                if ($urandom_range(0, 1)) append_code(code_of(-longint'($urandom_range(1, 300))));
                else append_code(random_info($urandom_range(2, 32)) | 32'd1);
                flush_stream();
            end else if (pick < 73) begin
                // positive count above the maximum
                append_code(random_info($urandom_range(18, 32)) & ~32'd1);
                flush_stream();
            end else if (pick < 76) begin
                // largest legal count, then cut short
                append_code(code_of(longint'(sevgd_pkg::MAX_COUNT)));
                repeat ($urandom_range(0, 3)) append_code(random_element_info());
                flush_stream();
                realign_to_count();
            end else if (pick < 78) begin
                // longest possible code, taken as a count
                append_code(random_info(32));
                flush_stream();
            end else if (pick < 90) begin
                // vector that stops early; unless the padding completes it, a zero run ends it with an element error
                n = $urandom_range(2, 8);
                append_code(code_of(n));
                repeat ($urandom_range(0, n - 1)) append_code(random_element_info());
                flush_stream();
                realign_to_count();
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                realign_to_count();
            end
            if (!drained && bytes_sent - start >= RANDOM_BYTES / 2) begin
                wait_drain();
                drained = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready pattern changes mode every so often
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_phase == 0) begin
            rx_mode  <= t_rx_mode'($urandom_range(0, 3));
            rx_phase <= $urandom_range(20, 200);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= (cycle_count % 5) != 0;
        endcase
    end

    // ------------------------------------------------------------------
    // Output checker: each transfer against the oldest decoded result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (decoded_fifo.size() == 0) begin
                $error("unexpected transfer: value %0d kind %0b",
                       $signed(o_m_axis_tdata[31:0]), o_m_axis_tuser);
                fail_count++;
            end else begin
                head_result = decoded_fifo.pop_front();
                if (o_m_axis_tuser !== head_result.kind) begin
                    $error("kind mismatch: expected %0b, got %0b", head_result.kind,
                           o_m_axis_tuser);
                    fail_count++;
                end
                if (o_m_axis_tdata[31:0] !== head_result.value) begin
                    $error("value mismatch: expected %0d, got %0d",
                           $signed(head_result.value), $signed(o_m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (o_m_axis_tlast !== head_result.last) begin
                    $error("last mismatch: expected %0b, got %0b", head_result.last,
                           o_m_axis_tlast);
                    fail_count++;
                end
                if (o_m_axis_tdata[32] !== head_result.err) begin
                    $error("error mismatch: expected %0b, got %0b", head_result.err,
                           o_m_axis_tdata[32]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("signed_exp_golomb_vector_decoder regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_value_extremes();
        wait_drain();
        test_count_specials();
        test_zero_run_at_count();
        wait_drain();
        test_dense_byte();
        wait_drain();
        test_random_vectors();
        wait_drain();

        if (fail_count == 0) begin
            $display("signed_exp_golomb_vector_decoder regression: pass");
        end else begin
            $display("signed_exp_golomb_vector_decoder regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sevgd_pkg.sv
rtl/sevgd_byte_queue.sv
rtl/sevgd_bit_engine.sv
rtl/signed_exp_golomb_vector_decoder.sv
sim/tb_top.sv
